// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; each use needs i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define KCL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("kcl assertion failed");

// Same check with a caller message.
`define KCL_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

// ----- hw/rtl/kcl_pkg.sv -----
package kcl_pkg;

    localparam int CODE_DIGITS = 5;
    localparam int CODE_BITS   = 4 * CODE_DIGITS;
    localparam int POS_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

    localparam int MODE_W   = 3;
    localparam int DIGITS_W = 3;
    localparam int EV_W     = 4;
    localparam int KEY_W    = 4;
    localparam int CNT_W    = 4;
    localparam int TICK_W   = 20;
    localparam int EMERG_W  = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // lock modes
    localparam logic [MODE_W-1:0] MODE_ENTER   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONFIRM = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OLD     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEW     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LOCKED  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ALARM   = 3'd6;

    // events
    localparam logic [EV_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EV_W-1:0] EV_DIGIT    = 4'd1;
    localparam logic [EV_W-1:0] EV_GRANTED  = 4'd2;
    localparam logic [EV_W-1:0] EV_WRONG    = 4'd3;
    localparam logic [EV_W-1:0] EV_LOCK     = 4'd4;
    localparam logic [EV_W-1:0] EV_UNLOCK   = 4'd5;
    localparam logic [EV_W-1:0] EV_ALARM    = 4'd6;
    localparam logic [EV_W-1:0] EV_PROMPT   = 4'd7;
    localparam logic [EV_W-1:0] EV_DECLINED = 4'd8;
    localparam logic [EV_W-1:0] EV_OLD_OK   = 4'd9;
    localparam logic [EV_W-1:0] EV_STORED   = 4'd10;
    localparam logic [EV_W-1:0] EV_EMERG_OK = 4'd11;

    // opcodes and keys
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CHANGE     = 4'd10;
    localparam logic [KEY_W-1:0] KEY_CONFIRM    = 4'd1;
    localparam logic [KEY_W-1:0] KEY_DECLINE    = 4'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRONG_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUTS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS     = 2'd3;

    localparam logic [EMERG_W-1:0] EMERG_RST    = 20'd0;
    localparam logic [CNT_W-1:0]   WRONG_RST    = 4'd3;
    localparam logic [CNT_W-1:0]   LOCKOUTS_RST = 4'd2;
    localparam logic [TICK_W-1:0]  TICKS_RST    = 20'd20000;

    typedef logic [CODE_BITS-1:0] t_code;

    typedef struct packed {
        logic [EMERG_W-1:0] emergency_code;
        logic [CNT_W-1:0]   wrong_limit;
        logic [CNT_W-1:0]   lockouts_to_alarm;
        logic [TICK_W-1:0]  lockout_ticks;
    } t_cfg;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key_code;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [DIGITS_W-1:0] digits_entered;
        logic [EV_W-1:0]     event_res;
        logic                green_lamp;
        logic                red_lamp;
        logic                buzzer_on;
    } t_res;

endpackage

// ----- hw/rtl/kcl_if.sv -----
interface kcl_in_if import kcl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output opcode, output key_code, input ready);
    modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

interface kcl_out_if import kcl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [DIGITS_W-1:0] digits_entered;
    logic [EV_W-1:0]     event_res;
    logic                green_lamp;
    logic                red_lamp;
    logic                buzzer_on;

    modport source (output valid, output mode, output digits_entered, output event_res,
                    output green_lamp, output red_lamp, output buzzer_on, input ready);
    modport sink   (input valid, input mode, input digits_entered, input event_res,
                    input green_lamp, input red_lamp, input buzzer_on, output ready);
endinterface

interface kcl_cfg_if import kcl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/kcl_cfg_regs.sv -----
module kcl_cfg_regs import kcl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcl_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.emergency_code    <= EMERG_RST;
            r_cfg.wrong_limit       <= WRONG_RST;
            r_cfg.lockouts_to_alarm <= LOCKOUTS_RST;
            r_cfg.lockout_ticks     <= TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_EMERGENCY: r_cfg.emergency_code    <= EMERG_W'(i_cfg.data);
                REG_WRONG_LIM: r_cfg.wrong_limit       <= CNT_W'(i_cfg.data);
                REG_LOCKOUTS:  r_cfg.lockouts_to_alarm <= CNT_W'(i_cfg.data);
                REG_TICKS:     r_cfg.lockout_ticks     <= TICK_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/kcl_core.sv -----
`include "assert_macros.svh"

module kcl_core import kcl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_step,
    input  t_item i_item,
    output t_res  o_res
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_DIGITS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    logic [MODE_W-1:0] r_mode,    n_mode;
    logic [POS_W-1:0]  r_pos,     n_pos;
    t_code             r_entry,   n_entry;
    t_code             r_stored,  n_stored;
    logic [CNT_W-1:0]  r_wrong,   n_wrong;
    logic [CNT_W-1:0]  r_lockcnt, n_lockcnt;
    logic [TICK_W-1:0] r_timer,   n_timer;
    logic              r_green,   n_green;
    logic              r_buzzer,  n_buzzer;

    logic [EV_W-1:0]   ev;
    t_code             shifted;
    logic              full;
    logic [POS_W-1:0]  pos_inc;
    logic [CNT_W-1:0]  wrong_inc;
    logic [CNT_W-1:0]  lock_inc;
    logic [CNT_W-1:0]  wrong_lim;
    logic [CNT_W-1:0]  alarm_lim;
    logic [TICK_W-1:0] tick_len;
    logic              wrong_hit;
    logic              is_tick;
    logic              is_digit;

    always_comb begin
        is_tick   = (i_item.opcode == OP_TICK);
        is_digit  = (i_item.key_code <= KEY_LAST_DIGIT);
        shifted   = CODE_BITS'({r_entry, i_item.key_code});
        full      = (r_pos == POS_LAST);
        pos_inc   = full ? '0 : r_pos + POS_W'(1);
        wrong_inc = (r_wrong != CNT_MAX) ? r_wrong + CNT_W'(1) : r_wrong;
        lock_inc  = (r_lockcnt != CNT_MAX) ? r_lockcnt + CNT_W'(1) : r_lockcnt;
        wrong_lim = (i_cfg.wrong_limit != '0) ? i_cfg.wrong_limit : CNT_W'(1);
        alarm_lim = (i_cfg.lockouts_to_alarm != '0) ? i_cfg.lockouts_to_alarm : CNT_W'(1);
        tick_len  = (i_cfg.lockout_ticks != '0) ? i_cfg.lockout_ticks : TICK_W'(1);
        wrong_hit = (wrong_inc >= wrong_lim);

        n_mode    = r_mode;
        n_pos     = r_pos;
        n_entry   = r_entry;
        n_stored  = r_stored;
        n_wrong   = r_wrong;
        n_lockcnt = r_lockcnt;
        n_timer   = r_timer;
        n_green   = r_green;
        n_buzzer  = r_buzzer;
        ev        = EV_NONE;

        if (is_tick) begin
            if (r_mode == MODE_LOCKED) begin
                if (r_timer > TICK_W'(1)) begin
                    n_timer = r_timer - TICK_W'(1);
                end else begin
                    n_timer = '0;
                    n_pos   = '0;
                    if (lock_inc >= alarm_lim) begin
                        n_lockcnt = '0;
                        n_buzzer  = 1'b1;
                        n_mode    = MODE_ALARM;
                        ev        = EV_ALARM;
                    end else begin
                        n_lockcnt = lock_inc;
                        n_mode    = MODE_ENTER;
                        ev        = EV_UNLOCK;
                    end
                end
            end
        end else if (is_digit) begin
            unique case (r_mode)
                MODE_ENTER, MODE_OLD, MODE_NEW, MODE_ALARM: begin
                    // shift the digit in; act once the last one arrives
                    n_entry = shifted;
                    n_pos   = pos_inc;
                    ev      = EV_DIGIT;
                    if (full) begin
                        if (r_mode == MODE_NEW) begin
                            n_stored = shifted;
                            n_green  = 1'b1;
                            n_mode   = MODE_OPEN;
                            ev       = EV_STORED;
                        end else if (r_mode == MODE_ALARM) begin
                            if (shifted == CODE_BITS'(i_cfg.emergency_code)) begin
                                n_stored = '0;
                                n_buzzer = 1'b0;
                                n_green  = 1'b1;
                                n_mode   = MODE_OPEN;
                                ev       = EV_EMERG_OK;
                            end else begin
                                ev = EV_WRONG;
                            end
                        end else if (shifted == r_stored) begin
                            if (r_mode == MODE_ENTER) begin
                                n_green = 1'b1;
                                n_mode  = MODE_OPEN;
                                ev      = EV_GRANTED;
                            end else begin
                                n_mode = MODE_NEW;
                                ev     = EV_OLD_OK;
                            end
                        end else if (wrong_hit) begin
                            n_wrong = '0;
                            n_timer = tick_len;
                            n_mode  = MODE_LOCKED;
                            ev      = EV_LOCK;
                            if (r_mode == MODE_OLD) begin
                                n_green = 1'b0;
                            end
                        end else begin
                            n_wrong = wrong_inc;
                            ev      = EV_WRONG;
                        end
                    end
                end
                MODE_CONFIRM: begin
                    if (i_item.key_code == KEY_CONFIRM) begin
                        n_mode = MODE_OLD;
                        n_pos  = '0;
                        ev     = EV_PROMPT;
                    end else if (i_item.key_code == KEY_DECLINE) begin
                        n_mode  = MODE_OPEN;
                        n_pos   = '0;
                        n_green = 1'b1;
                        ev      = EV_DECLINED;
                    end
                end
                default: ;
            endcase
        end else if (i_item.key_code == KEY_CHANGE && r_mode == MODE_OPEN) begin
            n_mode = MODE_CONFIRM;
            n_pos  = '0;
            ev     = EV_PROMPT;
        end

        o_res.mode           = n_mode;
        o_res.digits_entered = DIGITS_W'(n_pos);
        o_res.event_res      = ev;
        o_res.green_lamp     = n_green;
        o_res.red_lamp       = (n_mode == MODE_LOCKED);
        o_res.buzzer_on      = n_buzzer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ENTER;
            r_pos     <= '0;
            r_stored  <= '0;
            r_wrong   <= '0;
            r_lockcnt <= '0;
            r_timer   <= '0;
            r_green   <= 1'b0;
            r_buzzer  <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_stored  <= n_stored;
            r_wrong   <= n_wrong;
            r_lockcnt <= n_lockcnt;
            r_timer   <= n_timer;
            r_green   <= n_green;
            r_buzzer  <= n_buzzer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_entry <= n_entry;
        end
    end

    `KCL_ASSERT_MSG(a_buzzer_alarm, r_buzzer == (r_mode == MODE_ALARM), "buzzer out of step with alarm")
    `KCL_ASSERT_MSG(a_lock_timer, (r_mode == MODE_LOCKED) |-> (r_timer != '0), "lockout with idle timer")
    `KCL_ASSERT(a_timer_dec, (i_step && is_tick && r_mode == MODE_LOCKED && r_timer > TICK_W'(1)) |=> (r_timer == $past(r_timer) - TICK_W'(1)))
    `KCL_ASSERT(a_pos_idle, (r_mode == MODE_OPEN || r_mode == MODE_CONFIRM || r_mode == MODE_LOCKED) |-> (r_pos == '0))

endmodule

// ----- hw/rtl/keypad_code_lock_controller.sv -----
// Keypad code lock controller.
// Each request is held in an input register; its result is registered in the result register once that is free.
// Throughput: one request per cycle while the status side keeps ready high; the single-pass state update sets the pace.
// Reset: synchronous, active low; clears mode, counters, timer, lamps and the
// stored code (all zeros) and loads the register defaults.
module keypad_code_lock_controller import kcl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcl_cfg_if.sink   i_cfg,
    kcl_in_if.sink    i_in,
    kcl_out_if.source o_res
);

    t_cfg  cfg;
    t_res  core_res;

    logic  r_in_vld;
    t_item r_in_item;
    logic  r_out_vld;
    t_res  r_out;
    logic  advance;

    // Configuration register bank.
    kcl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Move the held request into the result register whenever the result
    // register is empty or being drained this cycle. The lock state updates
    // in the same edge, so the next request sees it right away.
    assign advance    = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready = !r_in_vld || advance;

    // Input register: capture a new request, or drop the held one once it
    // has moved on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.opcode   <= i_in.opcode;
            r_in_item.key_code <= i_in.key_code;
        end
    end

    // Lock state and the single-pass next-state logic.
    kcl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (advance),
        .i_item  (r_in_item),
        .o_res   (core_res)
    );

    // Result register: hold until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.mode           = r_out.mode;
    assign o_res.digits_entered = r_out.digits_entered;
    assign o_res.event_res      = r_out.event_res;
    assign o_res.green_lamp     = r_out.green_lamp;
    assign o_res.red_lamp       = r_out.red_lamp;
    assign o_res.buzzer_on      = r_out.buzzer_on;

endmodule

// ----- verif/kcl_lock_monitor.sv -----
module kcl_lock_monitor import kcl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    kcl_cfg_if   i_cfg,
    kcl_in_if    i_req,
    kcl_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Lock state as the block should hold it.
    logic [MODE_W-1:0] lk_mode;
    t_code             lk_code;
    t_code             lk_entry;
    logic [POS_W-1:0]  lk_pos;
    logic [CNT_W-1:0]  lk_wrong;
    logic [CNT_W-1:0]  lk_lockouts;
    logic [TICK_W-1:0] lk_timer;
    logic              lk_green;
    logic              lk_buzzer;

    // Register copies.
    logic [EMERG_W-1:0] cf_emerg;
    logic [CNT_W-1:0]   cf_wrong_lim;
    logic [CNT_W-1:0]   cf_lockouts;
    logic [TICK_W-1:0]  cf_ticks;

    t_res status_q[$];
    int   fail_total = 0;

    function automatic void reset_lock();
        lk_mode      = MODE_ENTER;
        lk_code      = '0;
        lk_entry     = '0;
        lk_pos       = '0;
        lk_wrong     = '0;
        lk_lockouts  = '0;
        lk_timer     = '0;
        lk_green     = 1'b0;
        lk_buzzer    = 1'b0;
        cf_emerg     = EMERG_RST;
        cf_wrong_lim = WRONG_RST;
        cf_lockouts  = LOCKOUTS_RST;
        cf_ticks     = TICKS_RST;
    endfunction

    function automatic void enter_mode(input logic [MODE_W-1:0] m);
        lk_mode = m;
        lk_pos  = '0;
    endfunction

    // Shift a digit in; true once a whole code is collected.
    function automatic logic push_digit(input logic [KEY_W-1:0] d);
        lk_entry = {lk_entry[CODE_BITS-KEY_W-1:0], d};
        if (int'(lk_pos) + 1 >= CODE_DIGITS) begin
            lk_pos = '0;
            return 1'b1;
        end
        lk_pos = lk_pos + 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [EV_W-1:0] count_wrong(input logic from_old);
        logic [CNT_W-1:0] lim;
        lim = (cf_wrong_lim == '0) ? CNT_W'(1) : cf_wrong_lim;
        if (lk_wrong != '1)
            lk_wrong = lk_wrong + 1'b1;
        if (lk_wrong >= lim) begin
            lk_wrong = '0;
            if (from_old)
                lk_green = 1'b0;
            lk_timer = (cf_ticks == '0) ? TICK_W'(1) : cf_ticks;
            enter_mode(MODE_LOCKED);
            return EV_LOCK;
        end
        return EV_WRONG;
    endfunction

    // Advance the lock by one request and return the status it reports.
    function automatic t_res step_lock(input t_item it);
        t_res             r;
        logic [EV_W-1:0]  ev;
        logic [CNT_W-1:0] lim;
        ev = EV_NONE;
        if (it.opcode == OP_TICK) begin
            if (lk_mode == MODE_LOCKED) begin
                if (lk_timer > TICK_W'(1)) begin
                    lk_timer = lk_timer - 1'b1;
                end else begin
                    lim = (cf_lockouts == '0) ? CNT_W'(1) : cf_lockouts;
                    lk_timer = '0;
                    if (lk_lockouts != '1)
                        lk_lockouts = lk_lockouts + 1'b1;
                    if (lk_lockouts >= lim) begin
                        lk_lockouts = '0;
                        lk_buzzer = 1'b1;
                        enter_mode(MODE_ALARM);
                        ev = EV_ALARM;
                    end else begin
                        enter_mode(MODE_ENTER);
                        ev = EV_UNLOCK;
                    end
                end
            end
        end else if (it.key_code <= KEY_LAST_DIGIT) begin
            case (lk_mode)
                MODE_ENTER: begin
                    ev = EV_DIGIT;
                    if (push_digit(it.key_code)) begin
                        if (lk_entry == lk_code) begin
                            lk_green = 1'b1;
                            enter_mode(MODE_OPEN);
                            ev = EV_GRANTED;
                        end else begin
                            ev = count_wrong(1'b0);
                        end
                    end
                end
                MODE_CONFIRM: begin
                    if (it.key_code == KEY_CONFIRM) begin
                        enter_mode(MODE_OLD);
                        ev = EV_PROMPT;
                    end else if (it.key_code == KEY_DECLINE) begin
                        lk_green = 1'b1;
                        enter_mode(MODE_OPEN);
                        ev = EV_DECLINED;
                    end
                end
                MODE_OLD: begin
                    ev = EV_DIGIT;
                    if (push_digit(it.key_code)) begin
                        if (lk_entry == lk_code) begin
                            enter_mode(MODE_NEW);
                            ev = EV_OLD_OK;
                        end else begin
                            ev = count_wrong(1'b1);
                        end
                    end
                end
                MODE_NEW: begin
                    ev = EV_DIGIT;
                    if (push_digit(it.key_code)) begin
                        lk_code = lk_entry;
                        lk_green = 1'b1;
                        enter_mode(MODE_OPEN);
                        ev = EV_STORED;
                    end
                end
                MODE_ALARM: begin
                    ev = EV_DIGIT;
                    if (push_digit(it.key_code)) begin
                        if (lk_entry == t_code'(cf_emerg)) begin
                            lk_code = '0;
                            lk_buzzer = 1'b0;
                            lk_green = 1'b1;
                            enter_mode(MODE_OPEN);
                            ev = EV_EMERG_OK;
                        end else begin
                            ev = EV_WRONG;
                        end
                    end
                end
                default: ;
            endcase
        end else if (it.key_code == KEY_CHANGE && lk_mode == MODE_OPEN) begin
            enter_mode(MODE_CONFIRM);
            ev = EV_PROMPT;
        end
        r.mode           = lk_mode;
        r.digits_entered = DIGITS_W'(lk_pos);
        r.event_res      = ev;
        r.green_lamp     = lk_green;
        r.red_lamp       = (lk_mode == MODE_LOCKED);
        r.buzzer_on      = lk_buzzer;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item req;
        t_res  want;
        t_res  got;
        if (!i_rst_n) begin
            reset_lock();
            status_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_EMERGENCY: cf_emerg     = i_cfg.data[EMERG_W-1:0];
                    REG_WRONG_LIM: cf_wrong_lim = i_cfg.data[CNT_W-1:0];
                    REG_LOCKOUTS:  cf_lockouts  = i_cfg.data[CNT_W-1:0];
                    REG_TICKS:     cf_ticks     = i_cfg.data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                req.opcode   = i_req.opcode;
                req.key_code = i_req.key_code;
                status_q.push_back(step_lock(req));
            end
            if (i_res.valid && i_res.ready) begin
                got.mode           = i_res.mode;
                got.digits_entered = i_res.digits_entered;
                got.event_res      = i_res.event_res;
                got.green_lamp     = i_res.green_lamp;
                got.red_lamp       = i_res.red_lamp;
                got.buzzer_on      = i_res.buzzer_on;
                if (status_q.size() == 0) begin
                    fail_total++;
                    $display("%0t ns: expected no result, actual mode %0d event %0d",
                             $time, got.mode, got.event_res);
                end else begin
                    want = status_q.pop_front();
                    check_field("mode", 8'(want.mode), 8'(got.mode));
                    check_field("digits_entered", 8'(want.digits_entered),
                                8'(got.digits_entered));
                    check_field("event_res", 8'(want.event_res), 8'(got.event_res));
                    check_field("green_lamp", 8'(want.green_lamp), 8'(got.green_lamp));
                    check_field("red_lamp", 8'(want.red_lamp), 8'(got.red_lamp));
                    check_field("buzzer_on", 8'(want.buzzer_on), 8'(got.buzzer_on));
                end
            end
        end
        o_pending    <= status_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- verif/tb_keypad_code_lock_controller.sv -----
module tb_keypad_code_lock_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import kcl_pkg::*;

    // Keys above the change key do nothing in any mode.
    localparam logic [KEY_W-1:0] KEY_IGNORED_LO = KEY_CHANGE + 1'b1;
    localparam logic [KEY_W-1:0] KEY_IGNORED_HI = '1;

    localparam int RANDOM_ITEMS  = 900;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;
    localparam int SQUEEZE_ITEMS = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    logic clk;
    logic rst_n;

    kcl_cfg_if cfg_bus();
    kcl_in_if  req_bus();
    kcl_out_if res_bus();

    int fails;
    int pending;

    // Sender side bookkeeping.
    int    sent;
    bit    tx_calm;
    logic  squeeze_req;
    t_code code_guess;
    t_code prev_code;
    t_code emerg_val;
    int    burst_span;

    keypad_code_lock_controller dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (req_bus),
        .o_res   (res_bus)
    );

    kcl_lock_monitor lock_mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_bus),
        .i_req        (req_bus),
        .i_res        (res_bus),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly back to back, now and then a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_code rand_code();
        t_code c;
        for (int i = 0; i < CODE_DIGITS; i++)
            c[KEY_W*i +: KEY_W] = KEY_W'($urandom_range(0, KEY_LAST_DIGIT));
        return c;
    endfunction

    // Pick the code most likely to be stored right now: the last one set,
    // the one before it, or the all-zero code after an emergency restore.
    function automatic t_code recall_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return code_guess;
        if (r < 85)
            return prev_code;
        return '0;
    endfunction

    // Offer one request and hold it until the block takes it. Valid stays
    // high into the next request when no gap is drawn.
    task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.opcode   <= op;
        req_bus.key_code <= key;
        do @(posedge clk); while (!req_bus.ready);
        if (!(op == OP_KEY && key > KEY_CHANGE))
            sent++;
    endtask

    // Type a whole code, first digit from the high nibble.
    task automatic send_code(input t_code c);
        for (int i = CODE_DIGITS - 1; i >= 0; i--)
            send_item(OP_KEY, c[KEY_W*i +: KEY_W]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cfg_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    // Drop the request valid, let every status come back, then settle the
    // pipe before touching the registers.
    task automatic program_lock(input logic [EMERG_W-1:0] emerg,
                                input logic [CNT_W-1:0]   wrong_lim,
                                input logic [CNT_W-1:0]   lockouts,
                                input logic [TICK_W-1:0]  ticks);
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_EMERGENCY, CFG_DATA_W'(emerg));
        write_reg(REG_WRONG_LIM, CFG_DATA_W'(wrong_lim));
        write_reg(REG_LOCKOUTS, CFG_DATA_W'(lockouts));
        write_reg(REG_TICKS, CFG_DATA_W'(ticks));
        cfg_bus.valid <= 1'b0;
        emerg_val  = t_code'(emerg);
        burst_span = (ticks > TICK_W'(40)) ? 43 : int'(ticks) + 3;
    endtask

    // One user interaction. Most are well formed so that the deep modes
    // (change, lockout, alarm) are reached; the rest are wrong or noise.
    task automatic run_scenario();
        int    pick;
        t_code code_a;
        t_code fresh;
        pick    = $urandom_range(0, 99);
        tx_calm = ($urandom_range(0, 9) < 2);
        code_a  = recall_code();
        fresh   = rand_code();
        if (pick < 25) begin
            send_code(code_a);
        end else if (pick < 40) begin
            // unlock, then walk the whole code change
            send_code(code_a);
            send_item(OP_KEY, KEY_CHANGE);
            send_item(OP_KEY, KEY_CONFIRM);
            send_code(code_a);
            send_code(fresh);
            prev_code  = code_a;
            code_guess = fresh;
        end else if (pick < 48) begin
            // unlock, ask for a change, then back out
            send_code(code_a);
            send_item(OP_KEY, KEY_CHANGE);
            if ($urandom_range(0, 1))
                send_item(OP_KEY, KEY_W'($urandom_range(KEY_DECLINE + 1, KEY_IGNORED_HI)));
            send_item(OP_KEY, KEY_DECLINE);
        end else if (pick < 56) begin
            // change attempt with a wrong old code
            send_code(code_a);
            send_item(OP_KEY, KEY_CHANGE);
            send_item(OP_KEY, KEY_CONFIRM);
            send_code(fresh);
        end else if (pick < 68) begin
            send_code(fresh);
        end else if (pick < 82) begin
            repeat ($urandom_range(1, burst_span))
                send_item(OP_TICK, KEY_W'($urandom_range(0, KEY_IGNORED_HI)));
        end else if (pick < 91) begin
            send_code(emerg_val);
            prev_code  = code_guess;
            code_guess = '0;
        end else begin
            repeat ($urandom_range(1, 4))
                send_item(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, KEY_IGNORED_HI)));
        end
    endtask

    task automatic run_phase(input int target);
        while (sent < target)
            run_scenario();
    endtask

    initial begin : stimulus
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_EMERGENCY;
        cfg_bus.data     <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.opcode   <= OP_KEY;
        req_bus.key_code <= '0;
        squeeze_req      <= 1'b0;
        rst_n            <= 1'b0;
        sent       = 0;
        tx_calm    = 1'b0;
        code_guess = '0;
        prev_code  = '0;
        emerg_val  = '0;
        burst_span = 4;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk. Zero limits act as one, so a single wrong entry
        // locks and a single lockout raises the alarm.
        program_lock(EMERG_W'(20'h90909), '0, '0, '0);
        send_item(OP_KEY, KEY_IGNORED_HI);       // ignored key while entering
        send_item(OP_TICK, '0);                  // tick with no lockout running
        send_code('0);                           // reset code grants access
        send_item(OP_KEY, KEY_CHANGE);
        send_item(OP_KEY, KEY_DECLINE);          // back out of the change
        send_item(OP_KEY, KEY_CHANGE);
        send_item(OP_KEY, KEY_CONFIRM);
        send_code({CODE_DIGITS{KEY_LAST_DIGIT}}); // wrong old code: lamp off, lockout
        send_item(OP_KEY, KEY_CHANGE);           // key during lockout
        send_item(OP_TICK, KEY_IGNORED_HI);      // lockout ends straight into alarm
        send_code(emerg_val);                    // emergency restore

        // Random part, one register setting per phase.
        sent = 0;
        program_lock(EMERG_W'(rand_code()), WRONG_RST, LOCKOUTS_RST, TICK_W'(6));

        // Hold the status side off while requests keep coming so the block
        // backs up and stalls its input.
        squeeze_req <= 1'b1;
        tx_calm = 1'b1;
        repeat (SQUEEZE_ITEMS)
            send_item(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, KEY_CHANGE)));
        tx_calm = 1'b0;
        run_phase(PHASE_ITEMS);

        program_lock('0, CNT_W'(1), CNT_W'(1), TICK_W'(1));
        run_phase(2 * PHASE_ITEMS);

        program_lock(EMERG_W'(rand_code()), '1, '1, TICK_W'($urandom_range(1, 12)));
        run_phase(3 * PHASE_ITEMS);

        program_lock(EMERG_W'(rand_code()), CNT_W'($urandom_range(1, 15)),
                     CNT_W'($urandom_range(1, 15)), TICK_W'($urandom_range(1, 40)));
        run_phase(RANDOM_ITEMS);

        // Top of every register range. A lockout this long cannot be waited
        // out, so feed only ticks and ignored keys here.
        program_lock('1, '1, '1, '1);
        repeat (24) begin
            if ($urandom_range(0, 1))
                send_item(OP_TICK, KEY_W'($urandom_range(0, KEY_IGNORED_HI)));
            else
                send_item(OP_KEY, KEY_W'($urandom_range(KEY_IGNORED_LO, KEY_IGNORED_HI)));
        end

        // Drain every outstanding status, then let the pipe settle.
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("keypad_code_lock_controller: match");
        else
            $display("keypad_code_lock_controller: mismatch");
        $finish;
    end

    // Status side: random stalls, stretches of steady ready, and one long
    // hold-off once the sender asks for it.
    initial begin : status_side
        int stall;
        int calm_left;
        bit squeeze_done;
        calm_left    = 0;
        squeeze_done = 1'b0;
        res_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else begin
                stall = pick_gap();
                if ($urandom_range(0, 39) == 0)
                    calm_left = $urandom_range(20, 80);
            end
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Give up well past the slowest legal run.
    initial begin : watchdog
        #3000000;
        $display("keypad_code_lock_controller: mismatch");
        $finish;
    end

endmodule

// ----- keypad_code_lock_controller.f -----
+incdir+hw/rtl
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_if.sv
hw/rtl/kcl_cfg_regs.sv
hw/rtl/kcl_core.sv
hw/rtl/keypad_code_lock_controller.sv
verif/kcl_lock_monitor.sv
verif/tb_keypad_code_lock_controller.sv
